// ===== hdl/lfu_pkg.sv =====
`timescale 1ns / 1ps
// Package for the LFU admission cache policy block.
// Holds the object table entry type, widths and the sequencer state type.
package lfu_pkg;

  localparam int NUM_OBJECTS = 256;
  localparam int IDX_W       = $clog2(NUM_OBJECTS);
  localparam int OBJ_ID_W    = 8;
  localparam int COUNT_W     = 16;
  localparam int STAMP_W     = 32;
  localparam int CAP_W       = 9;
  localparam int SCAN_W      = IDX_W + 1;

  localparam logic [COUNT_W-1:0] COUNT_MAX   = {COUNT_W{1'b1}};
  localparam logic [CAP_W-1:0]   CAP_RESET   = CAP_W'(64);

  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic               resident;
    logic [STAMP_W-1:0] stamp;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOKUP,
    S_SCAN,
    S_EVICT,
    S_ADMIT,
    S_FINISH
  } lfu_state_t;

endpackage

// ===== hdl/lfu_admission_cache_policy.sv =====
`timescale 1ns / 1ps
// Top level of the LFU admission cache policy block.
// Depends on lfu_pkg for the table entry type, widths and state type.

// One get request per input beat, one result beat per request. The per-object
// count, resident flag and order stamp sit in a single table memory with a
// registered read port; entries never written read as zero through a row of
// valid flops that reset clears, so no clearing pass is needed. A hit or a
// request that is not admitted goes from the lookup straight to the result;
// an admission into a non-full cache passes through the admit state first. A
// miss that finds the cache full scans every table entry through the one read
// port, one per cycle, drains the compare, and then evicts the least used
// resident entry if its count does not exceed the new one and admits. The next
// request is taken while a finished result still waits at the output.
module lfu_admission_cache_policy
  import lfu_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CAP_W-1:0]    capacity_objects,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [OBJ_ID_W-1:0] object_id,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                was_resident,
  output logic                admitted,
  output logic                evicted,
  output logic [OBJ_ID_W-1:0] victim_id,
  output logic [COUNT_W-1:0]  request_count
);

  lfu_state_t state, state_next;

  // Table memory and its valid row.
  entry_t                   table_mem [NUM_OBJECTS];
  logic [NUM_OBJECTS-1:0]   entry_valid;
  entry_t                   rd_data;
  logic                     rd_valid;
  entry_t                   rd_entry;
  logic                     mem_we;
  logic [IDX_W-1:0]         mem_waddr;
  entry_t                   mem_wdata;
  logic [IDX_W-1:0]         mem_raddr;

  // Control and working registers.
  logic [CAP_W-1:0]         cap_reg;
  logic [CAP_W-1:0]         cap_eff;
  logic [CAP_W-1:0]         resident_total;
  logic [STAMP_W-1:0]       stamp_counter;
  logic [IDX_W-1:0]         req_idx;
  logic [COUNT_W-1:0]       cnt_q;
  logic [COUNT_W-1:0]       cnt_new;
  logic                     was_q;
  logic                     adm_q;
  logic                     ev_q;
  logic [IDX_W-1:0]         vic_q;

  // Scan registers.
  logic [SCAN_W-1:0]        scan_idx;
  logic                     scan_done;
  logic                     cmp_pend;
  logic [IDX_W-1:0]         cmp_idx;
  logic                     best_found;
  logic [COUNT_W-1:0]       best_cnt;
  logic [STAMP_W-1:0]       best_stamp;
  logic [IDX_W-1:0]         best_idx;
  logic                     cand_better;

  logic                     out_free;
  logic                     in_accept;

  assign cfg_ready = 1'b1;
  assign cap_eff   = (cap_reg == '0) ? CAP_W'(1) : cap_reg;
  assign rd_entry  = rd_valid ? rd_data : '0;
  assign cnt_new   = (rd_entry.count == COUNT_MAX) ? COUNT_MAX : rd_entry.count + COUNT_W'(1);
  assign scan_done = (scan_idx == SCAN_W'(NUM_OBJECTS));
  assign out_free  = !out_valid || out_ready;
  assign in_accept = in_valid && in_ready;

  // Strict compares keep the lowest index among full ties.
  assign cand_better = rd_entry.resident &&
                       (!best_found || (rd_entry.count < best_cnt) ||
                        ((rd_entry.count == best_cnt) && (rd_entry.stamp < best_stamp)));

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_accept) state_next = S_LOOKUP;
      end
      S_LOOKUP: begin
        if (rd_entry.resident || cnt_new <= COUNT_W'(1)) begin
          state_next = S_FINISH;
        end else if (resident_total < cap_eff) begin
          state_next = S_ADMIT;
        end else begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_done && !cmp_pend) begin
          state_next = (best_found && best_cnt <= cnt_q) ? S_EVICT : S_FINISH;
        end
      end
      S_EVICT: begin
        state_next = ((resident_total - CAP_W'(1)) < cap_eff) ? S_ADMIT : S_FINISH;
      end
      S_ADMIT: state_next = S_FINISH;
      S_FINISH: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Handshake and memory port control.
  always_comb begin
    in_ready  = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = req_idx;
    mem_wdata = '0;
    mem_raddr = object_id[IDX_W-1:0];
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
      end
      S_LOOKUP: begin
        mem_we          = 1'b1;
        mem_wdata.count = cnt_new;
        if (rd_entry.resident) begin
          mem_wdata.resident = 1'b1;
          mem_wdata.stamp    = stamp_counter;
        end else begin
          // Count only; an admission rewrites the entry later.
          mem_wdata.resident = 1'b0;
          mem_wdata.stamp    = rd_entry.stamp;
        end
      end
      S_SCAN: begin
        mem_raddr = scan_idx[IDX_W-1:0];
      end
      S_EVICT: begin
        mem_we             = 1'b1;
        mem_waddr          = best_idx;
        mem_wdata.count    = best_cnt;
        mem_wdata.resident = 1'b0;
        mem_wdata.stamp    = best_stamp;
      end
      S_ADMIT: begin
        mem_we             = 1'b1;
        mem_wdata.count    = cnt_q;
        mem_wdata.resident = 1'b1;
        mem_wdata.stamp    = stamp_counter;
      end
      S_FINISH: begin
      end
      default: begin
      end
    endcase
  end

  // Table memory with a registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) table_mem[mem_waddr] <= mem_wdata;
    rd_data <= table_mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      rd_valid    <= 1'b0;
    end else begin
      if (mem_we) entry_valid[mem_waddr] <= 1'b1;
      rd_valid <= entry_valid[mem_raddr];
    end
  end

  // Sequencer and datapath registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      cap_reg        <= CAP_RESET;
      resident_total <= '0;
      stamp_counter  <= '0;
      out_valid      <= 1'b0;
      cmp_pend       <= 1'b0;
      best_found     <= 1'b0;
      scan_idx       <= '0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) cap_reg <= capacity_objects;
      if (state == S_FINISH && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_accept) begin
            req_idx <= object_id[IDX_W-1:0];
            was_q   <= 1'b0;
            adm_q   <= 1'b0;
            ev_q    <= 1'b0;
            vic_q   <= '0;
          end
        end
        S_LOOKUP: begin
          cnt_q      <= cnt_new;
          scan_idx   <= '0;
          cmp_pend   <= 1'b0;
          best_found <= 1'b0;
          if (rd_entry.resident) begin
            was_q         <= 1'b1;
            stamp_counter <= stamp_counter + STAMP_W'(1);
          end
        end
        S_SCAN: begin
          // The read issued last cycle is compared while the next is issued.
          cmp_pend <= !scan_done;
          cmp_idx  <= scan_idx[IDX_W-1:0];
          if (!scan_done) scan_idx <= scan_idx + SCAN_W'(1);
          if (cmp_pend && cand_better) begin
            best_found <= 1'b1;
            best_cnt   <= rd_entry.count;
            best_stamp <= rd_entry.stamp;
            best_idx   <= cmp_idx;
          end
        end
        S_EVICT: begin
          resident_total <= resident_total - CAP_W'(1);
          ev_q           <= 1'b1;
          vic_q          <= best_idx;
        end
        S_ADMIT: begin
          resident_total <= resident_total + CAP_W'(1);
          stamp_counter  <= stamp_counter + STAMP_W'(1);
          adm_q          <= 1'b1;
        end
        S_FINISH: begin
        end
        default: begin
        end
      endcase
    end
  end

  // Result beat payload.
  always_ff @(posedge clk) begin
    if (state == S_FINISH && out_free) begin
      was_resident  <= was_q;
      admitted      <= adm_q;
      evicted       <= ev_q;
      victim_id     <= OBJ_ID_W'(vic_q);
      request_count <= cnt_q;
    end
  end

endmodule
